// ----- design/afmf_pkg.sv -----
// afmf_pkg: item types, action codes and the fade envelope builder
// shared by the audio fifo mute/fade block. no dependencies.
`timescale 1ns / 1ps

package afmf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 7;
  localparam int ERR_W    = 8;
  localparam int WM_W     = 13;

  localparam logic [WM_W-1:0]  WM_RESET = 13'd128;
  localparam logic [ERR_W-1:0] ERR_MAX  = 8'hFF;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_PULL = 2'd1;
  localparam logic [1:0] ACT_MUTE = 2'd2;

  // decay ratio 0.9726 in q32
  localparam logic [63:0] ENV_BASE_Q32 = 64'd4177285120;

  typedef struct packed {
    logic [1:0]                 action;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
    logic [CNT_W-1:0]           count;
    logic                       mute;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last;
    logic                       underflow;
    logic [ERR_W-1:0]           error_total;
  } out_item_t;

  typedef logic [WM_W-1:0] cfg_word_t;

  // envelope entry idx: round(0.9726^idx * 2^shift), repeated q32 products
  // rounded half up; evaluated at elaboration only
  function automatic logic [15:0] env_entry(input int unsigned idx,
                                            input int unsigned shift);
    logic [95:0] v;
    logic [95:0] e;
    v = 96'd1 << 32;
    for (int unsigned k = 0; k < idx; k++) begin
      v = (v * {32'd0, ENV_BASE_Q32} + (96'd1 << 31)) >> 32;
    end
    e = ((v << shift) + (96'd1 << 31)) >> 32;
    return e[15:0];
  endfunction

endpackage

// ----- design/afmf_chan_if.sv -----
// afmf_chan_if: valid/ready channel carrying one payload item.
// payload type is a parameter; used with the afmf_pkg item types.
`timescale 1ns / 1ps

interface afmf_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/afmf_ram.sv -----
// afmf_ram: generic single-write, single-read ram with registered read.
// no dependencies.
`timescale 1ns / 1ps

module afmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/audio_fifo_mute_fade.sv -----
// audio_fifo_mute_fade: stereo sample fifo with mute and exponential fade.
// depends on afmf_pkg, afmf_chan_if and afmf_ram.
`timescale 1ns / 1ps

// channels: item_in (sink) carries push, pull and set-mute items; item_out
// (source) carries one result per pulled sample; cfg (sink) writes the low
// watermark and is always ready.
// push and set-mute items leave item_in ready. a pull is set up as it is
// accepted; then, if the block fades, a bit-serial divider forms the
// clog2(FADE_LEN+1)-bit quotient (8 bits at the defaults) that sizes the
// envelope steps; then one result per cycle issues while item_out is not
// stalled. the one-port sample store is read once per result that has a
// stored sample. item_in is held low until the last result is issued. a
// result is read from the store, then faded into the output register.
// a stall on item_out freezes the whole read pipeline; nothing is lost and
// the held result stays on the port.
// reset (synchronous, active high) empties the fifo, sets output muted,
// clears the error count and loads the watermark with 128. the store itself
// is not cleared; only entries already pushed are ever read.

module audio_fifo_mute_fade #(
  parameter int FIFO_DEPTH = 4096,
  parameter int FADE_LEN   = 150,
  parameter int FADE_SHIFT = 5,
  parameter int MAX_BLOCK  = 64
) (
  input logic        clk,
  input logic        rst,
  afmf_chan_if.sink   item_in,
  afmf_chan_if.source item_out,
  afmf_chan_if.sink   cfg
);

  localparam int PW  = $clog2(FIFO_DEPTH);
  localparam int FW  = $clog2(FIFO_DEPTH + 1);
  localparam int CW  = (FW > afmf_pkg::WM_W) ? FW : afmf_pkg::WM_W;
  localparam int LW  = $clog2(FADE_LEN + 1);
  localparam int DBW = $clog2(LW);
  localparam int IW  = $clog2(FADE_LEN);
  localparam int MW  = IW + 2;
  localparam int EW  = FADE_SHIFT + 1;
  localparam int SW  = afmf_pkg::SAMPLE_W;
  localparam int PRW = SW + EW + 1;
  localparam int NW  = afmf_pkg::CNT_W;
  localparam int LCAP = (FADE_LEN < 64) ? FADE_LEN : 64;

  localparam logic [NW-1:0]  L_CAP   = NW'(LCAP);
  localparam logic [NW-1:0]  MB_CAP  = NW'(MAX_BLOCK);
  localparam logic [LW-1:0]  L_VEC   = LW'(FADE_LEN);
  localparam logic [IW-1:0]  L_LAST  = IW'(FADE_LEN - 1);
  localparam logic [PW-1:0]  P_LAST  = PW'(FIFO_DEPTH - 1);
  localparam logic [FW-1:0]  F_FULL  = FW'(FIFO_DEPTH);
  localparam logic [MW-1:0]  M_LIMIT = MW'(FADE_LEN);
  localparam logic [DBW-1:0] DB_TOP  = DBW'(LW - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

  // envelope rom
  logic [EW-1:0] env_rom [FADE_LEN];
  for (genvar g = 0; g < FADE_LEN; g++) begin : g_env
    localparam logic [15:0] ENT = afmf_pkg::env_entry(g, FADE_SHIFT);
    assign env_rom[g] = ENT[EW-1:0];
  end

  // control state
  state_t                  state, state_next;
  logic [PW-1:0]           wr_ptr, rd_ptr;
  logic [FW-1:0]           fill;
  logic                    mreq, omuted;
  logic [afmf_pkg::ERR_W-1:0] err;
  logic [afmf_pkg::WM_W-1:0]  wm;
  logic                    v1;

  // block registers
  logic [NW-1:0]           blk_cnt, blk_did, blk_fc, blk_start, pos;
  logic                    blk_fade, blk_fout, blk_uf;
  logic [MW-1:0]           m;
  logic [NW-1:0]           acc;
  logic [DBW-1:0]          div_bit;
  logic [NW-1:0]           div_rem;
  logic [LW-1:0]           div_q;

  // first read stage
  logic                    has1, fade1, last1, uf1;
  logic [EW-1:0]           env1;
  logic [afmf_pkg::ERR_W-1:0] err1;

  // pull setup
  logic                    in_acc, pull_go, push_ok;
  logic [NW-1:0]           su_cnt, su_to_read, su_did, su_fc;
  logic                    su_uf, su_mreq, su_fade;
  logic [afmf_pkg::ERR_W-1:0] su_err;

  always_comb begin
    su_cnt = (item_in.data.count > MB_CAP) ? MB_CAP : item_in.data.count;
    if (!mreq) begin
      su_to_read = (!omuted || CW'(fill) >= CW'(wm)) ? su_cnt : '0;
    end else if (!omuted) begin
      su_to_read = (su_cnt < L_CAP) ? su_cnt : L_CAP;
    end else begin
      su_to_read = '0;
    end
    su_did  = (FW'(su_to_read) < fill) ? su_to_read : NW'(fill);
    su_uf   = su_did < su_to_read;
    su_mreq = mreq | su_uf;
    su_err  = (su_uf && !mreq && err != afmf_pkg::ERR_MAX) ? err + 1'b1 : err;
    su_fade = (su_to_read != '0) && (omuted != su_mreq);
    su_fc   = (su_did < L_CAP) ? su_did : L_CAP;
  end

  assign item_in.ready = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign in_acc        = item_in.valid && item_in.ready;
  assign pull_go       = in_acc && item_in.data.action == afmf_pkg::ACT_PULL
                         && su_cnt != '0;
  assign push_ok       = in_acc && item_in.data.action == afmf_pkg::ACT_PUSH
                         && fill < F_FULL;

  // pipeline advance
  logic en, issue, last_pos, has0, in_fade, env_ok;
  logic [IW-1:0] rom_idx;
  logic [EW-1:0] env0;

  assign en       = !item_out.valid || item_out.ready;
  assign issue    = (state == ST_RUN) && en;
  assign last_pos = pos == blk_cnt - 1'b1;
  assign has0     = pos < blk_did;
  assign in_fade  = blk_fade && (blk_fout ? (pos < blk_fc)
                                          : (pos >= blk_start && pos < blk_did));
  assign env_ok   = m < M_LIMIT;
  assign rom_idx  = blk_fout ? m[IW-1:0] : L_LAST - m[IW-1:0];
  assign env0     = env_ok ? env_rom[rom_idx] : '0;

  // bresenham step: acc += FADE_LEN folded into q*fc + r
  logic [NW:0]   a1;
  logic [LW:0]   step_k;
  logic [NW-1:0] acc_next;

  always_comb begin
    a1 = {1'b0, acc} + {1'b0, div_rem};
    if (a1 == '0) begin
      step_k   = {1'b0, div_q} - 1'b1;
      acc_next = blk_fc;
    end else if (a1 > {1'b0, blk_fc}) begin
      step_k   = {1'b0, div_q} + 1'b1;
      acc_next = NW'(a1 - {1'b0, blk_fc});
    end else begin
      step_k   = {1'b0, div_q};
      acc_next = NW'(a1);
    end
  end

  // divider trial
  logic [NW:0] div_trial;
  assign div_trial = {div_rem, L_VEC[div_bit]};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (pull_go) state_next = su_fade ? ST_DIV : ST_RUN;
      ST_DIV:  if (div_bit == '0) state_next = ST_RUN;
      ST_RUN:  if (en && last_pos) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sample store
  logic [2*SW-1:0] rdata;

  afmf_ram #(
    .WIDTH(2 * SW),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (push_ok),
    .waddr(wr_ptr),
    .wdata({item_in.data.in_right, item_in.data.in_left}),
    .re   (issue && has0),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      fill           <= '0;
      mreq           <= 1'b0;
      omuted         <= 1'b1;
      err            <= '0;
      wm             <= afmf_pkg::WM_RESET;
      v1             <= 1'b0;
      item_out.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        wm <= cfg.data;
      end
      if (push_ok) begin
        wr_ptr <= (wr_ptr == P_LAST) ? '0 : wr_ptr + 1'b1;
        fill   <= fill + 1'b1;
      end
      if (in_acc && item_in.data.action == afmf_pkg::ACT_MUTE) begin
        mreq <= item_in.data.mute;
      end
      if (pull_go) begin
        fill <= fill - FW'(su_did);
        mreq <= su_mreq;
        err  <= su_err;
        if (su_to_read != '0) begin
          omuted <= su_mreq;
        end
      end
      if (issue && has0) begin
        rd_ptr <= (rd_ptr == P_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (en) begin
        v1             <= (state == ST_RUN);
        item_out.valid <= v1;
      end
    end
  end

  // fade multiply on the stored sample
  logic signed [SW-1:0]  samp_l, samp_r;
  logic signed [EW:0]    env_s;
  logic signed [PRW-1:0] prod_l, prod_r, shr_l, shr_r;

  assign samp_l = has1 ? $signed(rdata[SW-1:0])    : '0;
  assign samp_r = has1 ? $signed(rdata[2*SW-1:SW]) : '0;
  assign env_s  = $signed({1'b0, env1});
  assign prod_l = PRW'(samp_l) * PRW'(env_s);
  assign prod_r = PRW'(samp_r) * PRW'(env_s);
  assign shr_l  = prod_l >>> FADE_SHIFT;
  assign shr_r  = prod_r >>> FADE_SHIFT;

  always_ff @(posedge clk) begin
    if (pull_go) begin
      blk_cnt   <= su_cnt;
      blk_did   <= su_did;
      blk_fc    <= su_fc;
      blk_start <= su_did - su_fc;
      blk_fade  <= su_fade;
      blk_fout  <= su_mreq;
      blk_uf    <= su_uf;
      pos       <= '0;
      m         <= '0;
      acc       <= '0;
      div_bit   <= DB_TOP;
      div_rem   <= '0;
      div_q     <= '0;
    end
    if (state == ST_DIV) begin
      if (div_trial >= {1'b0, blk_fc}) begin
        div_rem <= NW'(div_trial - {1'b0, blk_fc});
        div_q   <= {div_q[LW-2:0], 1'b1};
      end else begin
        div_rem <= NW'(div_trial);
        div_q   <= {div_q[LW-2:0], 1'b0};
      end
      div_bit <= div_bit - 1'b1;
    end
    if (issue) begin
      pos <= pos + 1'b1;
      if (in_fade) begin
        m   <= m + MW'(step_k);
        acc <= acc_next;
      end
    end
    if (en) begin
      has1  <= has0;
      fade1 <= in_fade;
      env1  <= env0;
      last1 <= last_pos;
      uf1   <= blk_uf;
      err1  <= err;
      item_out.data.out_left    <= fade1 ? shr_l[SW-1:0] : samp_l;
      item_out.data.out_right   <= fade1 ? shr_r[SW-1:0] : samp_r;
      item_out.data.last        <= last1;
      item_out.data.underflow   <= uf1;
      item_out.data.error_total <= err1;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= F_FULL)
    else $error("fill level above fifo depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> pos < blk_cnt)
    else $error("pull position past block length");

  a_env_range: assert property (@(posedge clk) disable iff (rst)
    issue && in_fade |-> env_ok)
    else $error("envelope index out of range inside fade");

  a_pull_busy: assert property (@(posedge clk) disable iff (rst)
    pull_go |=> state != ST_IDLE && !item_in.ready)
    else $error("pull accepted but block still idle");

endmodule

// ----- dv/afmf_checker.sv -----
// afmf_checker: predicts the result stream of audio_fifo_mute_fade from the
// items and watermark writes it sees, and compares every result. uses afmf_pkg.
`timescale 1ns / 1ps

module afmf_checker
  import afmf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_word_t cfg_data,
  output int        fail_total,
  output int        samples_left
);

  localparam int FIFO_D  = 4096;
  localparam int FADE_N  = 150;
  localparam int FADE_SH = 5;
  localparam int BLK_MAX = 64;
  localparam int PRINT_MAX = 30;
  // 0.9726f held exactly in q32
  localparam logic [95:0] DECAY_Q32 = 96'd4177285120;

  logic [31:0]      store_mem [FIFO_D];
  logic [11:0]      rd_ptr;
  logic [11:0]      wr_ptr;
  logic [12:0]      fill;
  logic             req_mute;
  logic             out_mute;
  logic [ERR_W-1:0] err_cnt;
  logic [5:0]       env_tab [FADE_N];
  cfg_word_t        wm;
  out_item_t        due_samples [$];
  int               fail_cnt = 0;
  int               out_seen = 0;

  task automatic clear_state();
    logic [95:0] v;
    logic [95:0] e;
    v = 96'd1 << 32;
    for (int i = 0; i < FADE_N; i++) begin
      e = ((v << FADE_SH) + (96'd1 << 31)) >> 32;
      env_tab[i] = e[5:0];
      v = (v * DECAY_Q32 + (96'd1 << 31)) >> 32;
    end
    rd_ptr   = '0;
    wr_ptr   = '0;
    fill     = '0;
    req_mute = 1'b0;
    out_mute = 1'b1;
    err_cnt  = '0;
    wm       = WM_RESET;
  endtask

  // product with the envelope, shifted down, rounding toward minus infinity
  function automatic logic signed [15:0] fade_scale(input logic signed [15:0] s,
                                                    input logic [5:0] g);
    int p;
    p = int'(s) * int'(g);
    p = p >>> FADE_SH;
    return p[15:0];
  endfunction

  task automatic report_mismatch(input string msg);
    fail_cnt++;
    if (fail_cnt <= PRINT_MAX) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic compute_block_out(input in_item_t it);
    logic signed [15:0] lb [BLK_MAX];
    logic signed [15:0] rb [BLK_MAX];
    int cnt, to_rd, got, fc, first, idx, stp, acc;
    logic uf;
    logic [5:0] g;
    out_item_t r;
    case (it.action)
      ACT_PUSH: begin
        // full store drops the sample
        if (fill < FIFO_D) begin
          store_mem[wr_ptr] = {it.in_right, it.in_left};
          wr_ptr = wr_ptr + 12'd1;
          fill = fill + 13'd1;
        end
      end
      ACT_MUTE: begin
        req_mute = it.mute;
      end
      ACT_PULL: begin
        cnt = int'(it.count);
        if (cnt > BLK_MAX) cnt = BLK_MAX;
        to_rd = 0;
        if (!req_mute) begin
          if (!out_mute || fill >= wm) to_rd = cnt;
        end else if (!out_mute) begin
          to_rd = (cnt < FADE_N) ? cnt : FADE_N;
        end
        for (int i = 0; i < BLK_MAX; i++) begin
          lb[i] = '0;
          rb[i] = '0;
        end
        uf = 1'b0;
        if (to_rd > 0) begin
          got = (to_rd < int'(fill)) ? to_rd : int'(fill);
          for (int i = 0; i < got; i++) begin
            lb[i] = store_mem[rd_ptr][15:0];
            rb[i] = store_mem[rd_ptr][31:16];
            rd_ptr = rd_ptr + 12'd1;
          end
          fill = fill - 13'(got);
          if (got < to_rd) begin
            uf = 1'b1;
            if (!req_mute) begin
              req_mute = 1'b1;
              if (err_cnt != ERR_MAX) err_cnt = err_cnt + 1'b1;
            end
          end
          if (out_mute != req_mute) begin
            fc = (got < FADE_N) ? got : FADE_N;
            acc = 0;
            if (req_mute) begin
              first = 0;
              idx = 0;
              stp = 1;
            end else begin
              first = got - fc;
              idx = FADE_N - 1;
              stp = -1;
            end
            for (int i = first; i < first + fc; i++) begin
              g = (idx >= 0 && idx < FADE_N) ? env_tab[idx] : 6'd0;
              lb[i] = fade_scale(lb[i], g);
              rb[i] = fade_scale(rb[i], g);
              acc += FADE_N;
              while (acc > fc) begin
                idx += stp;
                acc -= fc;
              end
            end
            out_mute = req_mute;
          end
        end
        for (int i = 0; i < cnt; i++) begin
          r.out_left    = lb[i];
          r.out_right   = rb[i];
          r.last        = (i == cnt - 1);
          r.underflow   = uf;
          r.error_total = err_cnt;
          due_samples.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_sample(input out_item_t got);
    out_item_t want;
    if (due_samples.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with none expected", out_seen));
    end else begin
      want = due_samples.pop_front();
      if (got.out_left !== want.out_left)
        report_mismatch($sformatf("result %0d out_left %0d, expected %0d",
                                  out_seen, got.out_left, want.out_left));
      if (got.out_right !== want.out_right)
        report_mismatch($sformatf("result %0d out_right %0d, expected %0d",
                                  out_seen, got.out_right, want.out_right));
      if (got.last !== want.last)
        report_mismatch($sformatf("result %0d last %b, expected %b",
                                  out_seen, got.last, want.last));
      if (got.underflow !== want.underflow)
        report_mismatch($sformatf("result %0d underflow %b, expected %b",
                                  out_seen, got.underflow, want.underflow));
      if (got.error_total !== want.error_total)
        report_mismatch($sformatf("result %0d error_total %0d, expected %0d",
                                  out_seen, got.error_total, want.error_total));
    end
    out_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      due_samples.delete();
    end else begin
      if (out_valid && out_ready) check_sample(out_data);
      if (cfg_valid && cfg_ready) wm = cfg_data;
      if (in_valid && in_ready) compute_block_out(in_data);
    end
    fail_total   <= fail_cnt;
    samples_left <= due_samples.size();
  end

endmodule

// ----- dv/testbench.sv -----
// testbench: drives push, pull and mute items and watermark writes into
// audio_fifo_mute_fade with random idling; afmf_checker judges the results.
`timescale 1ns / 1ps

module testbench;
  import afmf_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int STALL_LIMIT = 1000;

  logic clk;
  logic rst;
  bit   idle_on;
  int   quiet_cycles;
  int   fail_total;
  int   samples_left;

  afmf_chan_if #(.payload_t(in_item_t))  item_in ();
  afmf_chan_if #(.payload_t(out_item_t)) item_out ();
  afmf_chan_if #(.payload_t(cfg_word_t)) cfg ();

  audio_fifo_mute_fade DUT (
    .clk      (clk),
    .rst      (rst),
    .item_in  (item_in),
    .item_out (item_out),
    .cfg      (cfg)
  );

  afmf_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (item_in.valid),
    .in_ready     (item_in.ready),
    .in_data      (item_in.data),
    .out_valid    (item_out.valid),
    .out_ready    (item_out.ready),
    .out_data     (item_out.data),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_data     (cfg.data),
    .fail_total   (fail_total),
    .samples_left (samples_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side stalls in short bursts while idling is on
  initial begin
    item_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        item_out.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      item_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_in.valid && item_in.ready) || (item_out.valid && item_out.ready)
        || (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic in_item_t item_of(input logic [1:0] act);
    in_item_t it;
    it.action   = act;
    it.in_left  = 16'($urandom);
    it.in_right = 16'($urandom);
    it.count    = 7'($urandom);
    it.mute     = 1'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // valid is left high after the handshake so back-to-back items need no gap
  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      item_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_in.valid <= 1'b1;
    item_in.data  <= it;
    do @(posedge clk); while (!item_in.ready);
  endtask

  task automatic push(input logic [15:0] l, input logic [15:0] r);
    in_item_t it;
    it = item_of(ACT_PUSH);
    it.in_left  = l;
    it.in_right = r;
    send_item(it);
  endtask

  task automatic pull(input int c);
    in_item_t it;
    it = item_of(ACT_PULL);
    it.count = c[CNT_W-1:0];
    send_item(it);
  endtask

  task automatic set_mute(input logic m);
    in_item_t it;
    it = item_of(ACT_MUTE);
    it.mute = m;
    send_item(it);
  endtask

  // hold off until every expected result is out, then let the block settle
  task automatic wait_idle();
    item_in.valid <= 1'b0;
    @(posedge clk);
    while (samples_left != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_wm(input cfg_word_t v);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // mostly push bursts and pulls with mute changes sprinkled in
  task automatic random_phase(input int n_items);
    int sent;
    int pick;
    int c;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 24)) begin
          push(pick_sample(), pick_sample());
          sent++;
        end
      end else if (pick < 78) begin
        c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
        pull(c);
        if (c != 0) sent++;
      end else if (pick < 96) begin
        set_mute($urandom_range(0, 2) == 0);
        sent++;
      end else begin
        send_item(item_of(ACT_SPARE));
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    idle_on       = 1'b1;
    item_in.valid <= 1'b0;
    item_in.data  <= '0;
    cfg.valid     <= 1'b0;
    cfg.data      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default watermark: output stays silent, zero and oversized counts
    pull(0);
    send_item(item_of(ACT_SPARE));
    pull(3);
    push(16'h8000, 16'h7FFF);
    push(16'h7FFF, 16'h8000);
    push(16'hFFFF, 16'h0001);
    push(16'h0000, 16'h0000);
    pull(100);
    set_mute(1'b1);
    pull(2);
    set_mute(1'b0);
    wait_idle();

    // low watermark: fade in, underflow with fade out, underflow during fade-in
    write_wm(13'd2);
    pull(3);
    pull(2);
    pull(1);
    set_mute(1'b0);
    push(16'h8000, 16'h8000);
    push(16'h7FFF, 16'h7FFF);
    pull(64);
    set_mute(1'b0);
    repeat (4) push(pick_sample(), pick_sample());
    pull(2);
    set_mute(1'b1);
    pull(3);
    pull(1);
    wait_idle();

    write_wm(13'd1);
    random_phase(70);
    wait_idle();
    idle_on = 1'b0;
    write_wm(13'd0);
    random_phase(70);
    wait_idle();
    idle_on = 1'b1;
    write_wm(13'd24);
    random_phase(70);
    wait_idle();
    write_wm(13'd8191);
    random_phase(40);
    wait_idle();
    write_wm(cfg_word_t'($urandom_range(2, 60)));
    random_phase(70);
    wait_idle();

    // repeated underflows with output live raise the error count
    idle_on = 1'b0;
    write_wm(13'd0);
    repeat (55) begin
      set_mute(1'b0);
      pull($urandom_range(1, 64));
    end

    wait_idle();
    if (fail_total == 0 && samples_left == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
